### src/nlu_pkg.sv
// Shared types and constants of the neural loss unit.
`default_nettype none
package nlu_pkg;

  localparam int unsigned MAX_ELEMENTS = 1024;
  localparam int unsigned CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned QDEPTH       = 4;
  localparam int unsigned QPTR_W       = $clog2(QDEPTH);
  localparam int unsigned QLVL_W       = $clog2(QDEPTH + 1);
  localparam int unsigned SUM_W        = 48;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 15;

  localparam logic [CFG_IDX_W-1:0] REG_LOSS_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CLAMP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GPU_BYPASS = 2'd2;

  typedef enum logic [1:0] {
    MODE_CCE = 2'd0,
    MODE_BCE = 2'd1,
    MODE_MSE = 2'd2,
    MODE_MAE = 2'd3
  } mode_e;

  // One finished vector handed from the front to the back.
  typedef struct packed {
    mode_e              mode;
    logic [SUM_W-1:0]   sum;
    logic [CNT_W-1:0]   cnt;
    logic [31:0]        prob;
    logic               seen;
  } job_t;

endpackage
`default_nettype wire

### src/nlu_front.sv
// Front: accepts element words, picks the target, accumulates the error sum.
`default_nettype none
module nlu_front import nlu_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [31:0]       predicted_i,
  input  wire logic [31:0]       expected_i,
  input  wire logic [9:0]        target_index_i,
  input  wire logic              last_i,
  input  wire mode_e             mode_i,
  input  wire logic [QLVL_W-1:0] q_level_i,
  output logic                   push_o,
  output job_t                   push_job_o
);

  logic             accept;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]      prob_q, prob_d;
  logic             seen_q, seen_d;
  logic             pick;
  logic signed [32:0] diff;
  logic [32:0]      ad;

  logic             a_vld_q, a_last_q, a_seen_q;
  logic [32:0]      a_ad_q;
  mode_e            a_mode_q;
  logic [CNT_W-1:0] a_cnt_q;
  logic [31:0]      a_prob_q;

  logic             b_vld_q, b_last_q, b_seen_q;
  logic [48:0]      b_add_q;
  logic [65:0]      sq;
  mode_e            b_mode_q;
  logic [CNT_W-1:0] b_cnt_q;
  logic [31:0]      b_prob_q;

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [SUM_W+1:0] sum_wide;
  logic [QLVL_W-1:0] pending;

  // Every last word still in flight needs a free queue slot.
  assign pending    = q_level_i + QLVL_W'(a_vld_q & a_last_q) + QLVL_W'(b_vld_q & b_last_q);
  assign in_stall_o = (pending >= QLVL_W'(QDEPTH));
  assign accept     = in_valid_i & ~in_stall_o;

  assign pick  = ~seen_q && (cnt_q == CNT_W'(target_index_i)) && (cnt_q < CNT_W'(MAX_ELEMENTS));
  assign cnt_d = (cnt_q < CNT_W'(MAX_ELEMENTS)) ? cnt_q + CNT_W'(1) : cnt_q;
  assign prob_d = pick ? expected_i : prob_q;
  assign seen_d = seen_q | pick;

  assign diff = {predicted_i[31], predicted_i} - {expected_i[31], expected_i};
  assign ad   = diff[32] ? 33'(-diff) : 33'(diff);

  assign sq = a_ad_q * a_ad_q;

  assign sum_wide = {2'b00, sum_q} + {1'b0, b_add_q};
  always_comb begin
    sum_d = sum_q;
    if (b_mode_q == MODE_MSE || b_mode_q == MODE_MAE) begin
      sum_d = (|sum_wide[SUM_W+1:SUM_W]) ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    end
  end

  assign push_o          = b_vld_q & b_last_q;
  assign push_job_o.mode = b_mode_q;
  assign push_job_o.sum  = sum_d;
  assign push_job_o.cnt  = b_cnt_q;
  assign push_job_o.prob = b_prob_q;
  assign push_job_o.seen = b_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      prob_q  <= '0;
      seen_q  <= 1'b0;
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      sum_q   <= '0;
    end else begin
      a_vld_q <= accept;
      b_vld_q <= a_vld_q;
      if (accept) begin
        if (last_i) begin
          cnt_q  <= '0;
          prob_q <= '0;
          seen_q <= 1'b0;
        end else begin
          cnt_q  <= cnt_d;
          prob_q <= prob_d;
          seen_q <= seen_d;
        end
      end
      if (b_vld_q) begin
        sum_q <= b_last_q ? '0 : sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_ad_q   <= ad;
      a_mode_q <= mode_i;
      a_last_q <= last_i;
      a_cnt_q  <= cnt_d;
      a_prob_q <= prob_d;
      a_seen_q <= seen_d;
    end
    if (a_vld_q) begin
      b_add_q  <= (a_mode_q == MODE_MSE) ? sq[64:16] : {16'd0, a_ad_q};
      b_mode_q <= a_mode_q;
      b_last_q <= a_last_q;
      b_cnt_q  <= a_cnt_q;
      b_prob_q <= a_prob_q;
      b_seen_q <= a_seen_q;
    end
  end

endmodule
`default_nettype wire

### src/nlu_queue.sv
// Short queue of finished vectors between the front and the back.
`default_nettype none
module nlu_queue import nlu_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire job_t              push_job_i,
  input  wire logic              pop_i,
  output logic                   job_valid_o,
  output job_t                   job_o,
  output logic [QLVL_W-1:0]      level_o
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QLVL_W-1:0] lvl_q;

  assign job_valid_o = (lvl_q != '0);
  assign job_o       = mem[rd_q];
  assign level_o     = lvl_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QPTR_W'(1);
      if (pop_i)  rd_q <= rd_q + QPTR_W'(1);
      lvl_q <= lvl_q + QLVL_W'(push_i) - QLVL_W'(pop_i);
    end
  end

endmodule
`default_nettype wire

### src/nlu_back.sv
// Back: divides the sum by the count (or gives zero in GPU bypass) or evaluates the entropy logarithms.
`default_nettype none
module nlu_back import nlu_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  job_valid_i,
  input  wire job_t                  job_i,
  output logic                       pop_o,
  input  wire logic [CFG_DATA_W-1:0] min_clamp_i,
  input  wire logic                  gpu_bypass_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [31:0]                loss_o,
  output logic                       index_missing_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_NORM, S_SQR, S_SCL, S_ACC, S_DONE
  } state_e;

  state_e           state_q;
  mode_e            mode_q;
  logic [SUM_W-1:0] wk_q;
  logic [CNT_W-1:0] cnt_q, rem_q;
  logic [5:0]       step_q;
  logic [30:0]      m_q;
  logic [4:0]       k_q;
  logic [15:0]      frac_q;
  logic [3:0]       it_q;
  logic [20:0]      lnmag_q;
  logic [16:0]      opa_q, opb_q;
  logic             second_q;
  logic [39:0]      acc_q;
  logic [31:0]      res_loss_q;
  logic             res_miss_q;
  logic [31:0]      loss_q;
  logic             miss_q;
  logic             out_valid_q;

  // Start values.
  logic [15:0]        cl;
  logic signed [31:0] p;
  logic [16:0]        hi;
  logic signed [31:0] p_hi, p_bce;
  logic [30:0]        x_cce;
  logic [16:0]        b_bce;

  // Divider step.
  logic [CNT_W:0]   r2;
  logic             qbit;
  logic [SUM_W-1:0] wk_n;

  // Log steps.
  logic [61:0] sq;
  logic [31:0] t;
  logic [20:0] mag;
  logic        l2neg;
  logic [36:0] scaled;
  logic [37:0] term;
  logic [39:0] acc_n, acc_r;

  assign cl    = (min_clamp_i == '0) ? 16'd1 : {1'b0, min_clamp_i};
  assign p     = job_i.seen ? job_i.prob : 32'sd0;
  assign x_cce = (p < $signed({16'd0, cl})) ? {15'd0, cl} : p[30:0];
  assign hi    = 17'h10000 - {1'b0, cl};
  assign p_hi  = (p > $signed({15'd0, hi})) ? $signed({15'd0, hi}) : p;
  assign p_bce = (p_hi < $signed({16'd0, cl})) ? $signed({16'd0, cl}) : p_hi;
  assign b_bce = 17'h10000 - p_bce[16:0];

  assign r2   = {rem_q, wk_q[SUM_W-1]};
  assign qbit = (r2 >= {1'b0, cnt_q});
  assign wk_n = {wk_q[SUM_W-2:0], qbit};

  assign sq = m_q * m_q;
  assign t  = sq[61:30];

  // log2 = k + frac - 16; take its magnitude and scale by ln 2 with rounding.
  assign l2neg  = (k_q < 5'd16);
  assign mag    = l2neg ? ({5'd16 - k_q, 16'd0} - {5'd0, frac_q})
                        : ({k_q - 5'd16, 16'd0} + {5'd0, frac_q});
  assign scaled = mag * 16'd45426 + 37'd32768;

  assign term  = opa_q * lnmag_q;
  assign acc_n = acc_q + {2'b00, term};
  assign acc_r = acc_n + 40'd32768;

  assign pop_o           = (state_q == S_IDLE) & job_valid_i;
  assign out_valid_o     = out_valid_q;
  assign loss_o          = loss_q;
  assign index_missing_o = miss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_MSE;
      wk_q        <= '0;
      cnt_q       <= '0;
      rem_q       <= '0;
      step_q      <= '0;
      m_q         <= '0;
      k_q         <= '0;
      frac_q      <= '0;
      it_q        <= '0;
      lnmag_q     <= '0;
      opa_q       <= '0;
      opb_q       <= '0;
      second_q    <= 1'b0;
      acc_q       <= '0;
      res_loss_q  <= '0;
      res_miss_q  <= 1'b0;
      loss_q      <= '0;
      miss_q      <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_DONE) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            mode_q     <= job_i.mode;
            res_miss_q <= ~job_i.mode[1] & ~job_i.seen;
            wk_q       <= job_i.sum;
            cnt_q      <= job_i.cnt;
            rem_q      <= '0;
            step_q     <= 6'(SUM_W - 1);
            k_q        <= 5'd30;
            frac_q     <= '0;
            it_q       <= 4'd15;
            acc_q      <= '0;
            second_q   <= 1'b0;
            opa_q      <= p_bce[16:0];
            opb_q      <= b_bce;
            if (job_i.mode == MODE_CCE) begin
              m_q     <= x_cce;
              state_q <= S_NORM;
            end else if (job_i.mode == MODE_BCE) begin
              m_q     <= {14'd0, p_bce[16:0]};
              state_q <= S_NORM;
            end else if (gpu_bypass_i) begin
              res_loss_q <= '0;
              state_q    <= S_DONE;
            end else begin
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem_q  <= qbit ? CNT_W'(r2 - {1'b0, cnt_q}) : r2[CNT_W-1:0];
          wk_q   <= wk_n;
          step_q <= step_q - 6'd1;
          if (step_q == '0) begin
            res_loss_q <= (|wk_n[SUM_W-1:32]) ? 32'hFFFF_FFFF : wk_n[31:0];
            state_q    <= S_DONE;
          end
        end
        S_NORM: begin
          if (m_q[30]) begin
            state_q <= S_SQR;
          end else begin
            m_q <= {m_q[29:0], 1'b0};
            k_q <= k_q - 5'd1;
          end
        end
        S_SQR: begin
          if (t[31]) begin
            m_q          <= t[31:1];
            frac_q[it_q] <= 1'b1;
          end else begin
            m_q <= t[30:0];
          end
          it_q <= it_q - 4'd1;
          if (it_q == '0) state_q <= S_SCL;
        end
        S_SCL: begin
          lnmag_q <= scaled[36:16];
          if (mode_q == MODE_CCE) begin
            res_loss_q <= l2neg ? {11'd0, scaled[36:16]} : 32'd0;
            state_q    <= S_DONE;
          end else begin
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          acc_q <= acc_n;
          if (!second_q) begin
            second_q <= 1'b1;
            opa_q    <= opb_q;
            m_q      <= {14'd0, opb_q};
            k_q      <= 5'd30;
            frac_q   <= '0;
            it_q     <= 4'd15;
            state_q  <= S_NORM;
          end else begin
            res_loss_q <= {8'd0, acc_r[39:16]};
            state_q    <= S_DONE;
          end
        end
        S_DONE: begin
          // The output register only takes the new word once the previous one has left.
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            loss_q      <= res_loss_q;
            miss_q      <= res_miss_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### src/neural_loss_unit.sv
// Top level of the neural loss unit: configuration registers, front, queue and back.
//
//  channel | direction | handshake              | word
//  input   | in        | in_valid_i / in_stall_o | predicted, expected, target_index, last
//  output  | out       | out_valid_o / out_stall_i | loss, index_missing
//  config  | in        | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// The front takes one element word per cycle while in_stall_o is low; a last word passes
// its a and b registers before it is pushed into the queue. The back finds a mean one
// quotient bit per cycle (zero in GPU bypass), cross entropy by normalize, 16 squarings and
// scale, binary entropy by those steps for both logarithms. One finished loss waits in the
// output register while the back works on the next vector. Input stalls when the queued
// vectors plus last words in the front reach four. Reset clears all control state and loads the defaults.
`default_nettype none
module neural_loss_unit import nlu_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [31:0]           predicted_i,
  input  wire logic [31:0]           expected_i,
  input  wire logic [9:0]            target_index_i,
  input  wire logic                  last_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [31:0]                loss_o,
  output logic                       index_missing_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  mode_e                 mode_q;
  logic [CFG_DATA_W-1:0] clamp_q;
  logic                  bypass_q;

  logic              push;
  job_t              push_job;
  logic              pop;
  logic              job_valid;
  job_t              job;
  logic [QLVL_W-1:0] level;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_MSE;
      clamp_q  <= CFG_DATA_W'(1);
      bypass_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_LOSS_MODE)  mode_q   <= mode_e'(cfg_data_i[1:0]);
      if (cfg_idx_i == REG_MIN_CLAMP)  clamp_q  <= cfg_data_i;
      if (cfg_idx_i == REG_GPU_BYPASS) bypass_q <= cfg_data_i[0];
    end
  end

  nlu_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .predicted_i    (predicted_i),
    .expected_i     (expected_i),
    .target_index_i (target_index_i),
    .last_i         (last_i),
    .mode_i         (mode_q),
    .q_level_i      (level),
    .push_o         (push),
    .push_job_o     (push_job)
  );

  nlu_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_job_i  (push_job),
    .pop_i       (pop),
    .job_valid_o (job_valid),
    .job_o       (job),
    .level_o     (level)
  );

  nlu_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (job_valid),
    .job_i           (job),
    .pop_o           (pop),
    .min_clamp_i     (clamp_q),
    .gpu_bypass_i    (bypass_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .loss_o          (loss_o),
    .index_missing_o (index_missing_o)
  );

endmodule
`default_nettype wire
